>>> hw/rtl/ps2mt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ps2mt_pkg;

  localparam int POS_BITS  = 12;
  localparam int BOUND_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int POS_LIMIT = 1 << POS_BITS;
  localparam int POS_MAX   = POS_LIMIT - 1;
  localparam int CMP_W     = (BOUND_W > POS_BITS + 1) ? BOUND_W : POS_BITS + 1;
  localparam int CALC_W    = POS_BITS + 2;

  localparam int DELTA_LIM = 120;

  localparam logic [7:0] FLAG_SYNC_MASK = 8'h08;
  localparam logic [7:0] FLAG_BAD_MASK  = 8'hC0;
  localparam logic [7:0] FLAG_XSIGN     = 8'h10;
  localparam logic [7:0] FLAG_YSIGN     = 8'h20;
  localparam logic [7:0] FLAG_LEFT      = 8'h01;
  localparam logic [7:0] FLAG_RIGHT     = 8'h02;
  localparam logic [7:0] FLAG_MIDDLE    = 8'h04;

  localparam logic [BOUND_W-1:0] WIDTH_RST  = BOUND_W'(800);
  localparam logic [BOUND_W-1:0] HEIGHT_RST = BOUND_W'(600);
  localparam logic [POS_BITS-1:0] CURSOR_X_RST =
    POS_BITS'((400 > POS_MAX) ? POS_MAX : 400);
  localparam logic [POS_BITS-1:0] CURSOR_Y_RST =
    POS_BITS'((300 > POS_MAX) ? POS_MAX : 300);

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    PH_FLAG = 3'b001,
    PH_DX   = 3'b010,
    PH_DY   = 3'b100
  } phase_t;

  // Largest legal coordinate for a bound: zero acts as 1, oversize saturates.
  function automatic logic [POS_BITS-1:0] bound_hi(input logic [BOUND_W-1:0] b);
    logic [CMP_W-1:0] bw;
    logic [POS_BITS-1:0] hi;
    bw = CMP_W'(b);
    if (bw == '0) begin
      hi = '0;
    end else if (bw > CMP_W'(POS_LIMIT)) begin
      hi = POS_BITS'(POS_MAX);
    end else begin
      hi = POS_BITS'(bw - CMP_W'(1));
    end
    return hi;
  endfunction

  function automatic logic [POS_BITS-1:0] clamp_pos(input logic signed [CALC_W-1:0] v,
                                                     input logic [POS_BITS-1:0] hi);
    logic [POS_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b00, hi})) begin
      r = hi;
    end else begin
      r = POS_BITS'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ps2_mouse_packet_tracker_top.sv
// PS/2 mouse packet tracker.
// Input channel (in_valid/in_ready, rx_byte) takes raw mouse bytes. Bytes are
// framed into flag / dx / dy packets; while waiting for a flag byte, bytes
// with bit 3 clear or bits 7:6 nonzero are dropped. Each completed packet
// yields one transaction on the output channel (out_valid/out_ready) carrying
// the clamped cursor position, the three buttons and motion_applied.
// Accepts one byte per cycle while in_ready is high. The result of a packet is
// valid the cycle after its third byte is accepted; one output register holds it.
// in_ready is high when the output register is empty or is being drained in
// the same cycle, so a stalled receiver holds off input only while a result
// waits. Bounds are written through cfg_write/cfg_index/cfg_data (index 0
// width, index 1 height) and apply from the next accepted motion.
// Synchronous reset: no result pending, waiting for a flag byte, buttons
// released, cursor at 400,300, bounds 800 x 600.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_tracker_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [ps2mt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ps2mt_pkg::BOUND_W-1:0]      cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [7:0]                         rx_byte,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [ps2mt_pkg::POS_BITS-1:0]          x_position,
  output logic [ps2mt_pkg::POS_BITS-1:0]          y_position,
  output logic                                    left_button,
  output logic                                    right_button,
  output logic                                    middle_button,
  output logic                                    motion_applied
);

  logic [ps2mt_pkg::BOUND_W-1:0]  width_bound;
  logic [ps2mt_pkg::BOUND_W-1:0]  height_bound;
  ps2mt_pkg::phase_t              phase;
  ps2mt_pkg::phase_t              phase_next;
  logic [7:0]                     flag_byte;
  logic [7:0]                     dx_byte;
  logic [ps2mt_pkg::POS_BITS-1:0] cursor_x;
  logic [ps2mt_pkg::POS_BITS-1:0] cursor_y;
  logic [ps2mt_pkg::POS_BITS-1:0] cursor_x_next;
  logic [ps2mt_pkg::POS_BITS-1:0] cursor_y_next;
  logic [2:0]                     button_bits;
  logic                           applied;

  logic                           in_fire;
  logic                           flag_ok;
  logic                           pkt_done;
  logic signed [8:0]              dx;
  logic signed [8:0]              dy;
  logic signed [ps2mt_pkg::CALC_W-1:0] sum_x;
  logic signed [ps2mt_pkg::CALC_W-1:0] sum_y;
  logic                           applied_next;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign flag_ok = ((rx_byte & ps2mt_pkg::FLAG_SYNC_MASK) != '0) &&
                   ((rx_byte & ps2mt_pkg::FLAG_BAD_MASK) == '0);

  assign dx = {((flag_byte & ps2mt_pkg::FLAG_XSIGN) != '0), dx_byte};
  assign dy = {((flag_byte & ps2mt_pkg::FLAG_YSIGN) != '0), rx_byte};

  assign applied_next = (dx > -ps2mt_pkg::DELTA_LIM) && (dx < ps2mt_pkg::DELTA_LIM) &&
                        (dy > -ps2mt_pkg::DELTA_LIM) && (dy < ps2mt_pkg::DELTA_LIM);

  assign sum_x = $signed({2'b00, cursor_x}) + ps2mt_pkg::CALC_W'(dx);
  assign sum_y = $signed({2'b00, cursor_y}) - ps2mt_pkg::CALC_W'(dy);

  assign cursor_x_next = ps2mt_pkg::clamp_pos(sum_x, ps2mt_pkg::bound_hi(width_bound));
  assign cursor_y_next = ps2mt_pkg::clamp_pos(sum_y, ps2mt_pkg::bound_hi(height_bound));

  always_comb begin
    phase_next = ps2mt_pkg::PH_FLAG;
    pkt_done   = 1'b0;
    unique case (phase)
      ps2mt_pkg::PH_DX: begin
        phase_next = ps2mt_pkg::PH_DY;
      end
      ps2mt_pkg::PH_DY: begin
        phase_next = ps2mt_pkg::PH_FLAG;
        pkt_done   = 1'b1;
      end
      default: begin
        phase_next = flag_ok ? ps2mt_pkg::PH_DX : ps2mt_pkg::PH_FLAG;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_bound  <= ps2mt_pkg::WIDTH_RST;
      height_bound <= ps2mt_pkg::HEIGHT_RST;
    end else if (cfg_write) begin
      if (cfg_index == ps2mt_pkg::REG_WIDTH) begin
        width_bound <= cfg_data;
      end else if (cfg_index == ps2mt_pkg::REG_HEIGHT) begin
        height_bound <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ps2mt_pkg::PH_FLAG;
      flag_byte   <= '0;
      dx_byte     <= '0;
      cursor_x    <= ps2mt_pkg::CURSOR_X_RST;
      cursor_y    <= ps2mt_pkg::CURSOR_Y_RST;
      button_bits <= '0;
      applied     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        phase <= phase_next;
        if (phase == ps2mt_pkg::PH_DX) begin
          dx_byte <= rx_byte;
        end
        if (phase != ps2mt_pkg::PH_DX && phase != ps2mt_pkg::PH_DY && flag_ok) begin
          flag_byte <= rx_byte;
        end
        if (pkt_done) begin
          button_bits <= flag_byte[2:0];
          applied     <= applied_next;
          out_valid   <= 1'b1;
          if (applied_next) begin
            cursor_x <= cursor_x_next;
            cursor_y <= cursor_y_next;
          end
        end
      end
    end
  end

  // Cursor and buttons change only when a result is loaded.
  assign x_position     = cursor_x;
  assign y_position     = cursor_y;
  assign left_button    = (button_bits & ps2mt_pkg::FLAG_LEFT[2:0]) != '0;
  assign right_button   = (button_bits & ps2mt_pkg::FLAG_RIGHT[2:0]) != '0;
  assign middle_button  = (button_bits & ps2mt_pkg::FLAG_MIDDLE[2:0]) != '0;
  assign motion_applied = applied;

  a_result_after_dy: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == ps2mt_pkg::PH_DY |=> out_valid)
    else $error("completed packet produced no result");

  a_no_result_other_bytes: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase != ps2mt_pkg::PH_DY |=> !out_valid)
    else $error("result appeared without a completed packet");

  a_rejected_keeps_cursor: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == ps2mt_pkg::PH_DY && !applied_next |=>
      $stable(cursor_x) && $stable(cursor_y) && !motion_applied)
    else $error("rejected motion moved the cursor");

  a_held_result_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(cursor_x) && $stable(cursor_y) &&
      $stable(button_bits) && $stable(applied))
    else $error("pending result changed while stalled");

endmodule

`default_nettype wire
